### rtl/b64d_pkg.sv
// shared types, constants and decode functions of the base64 stream decoder
`timescale 1ns / 1ps

package b64d_pkg;

  localparam logic [7:0] PadChar  = 8'h3D;
  localparam int unsigned AccW    = 18;
  localparam int unsigned GroupW  = 24;
  localparam int unsigned CntW    = 3;
  localparam int unsigned NumW    = 2;

  // one decoded group as queued between the front and the back
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [NumW-1:0] num;
    logic            done;
  } rec_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  // msb flags an alphabet character, low six bits carry its value
  function automatic logic [6:0] sextet_of(logic [7:0] c);
    logic [7:0] res;
    logic       hit;
    res = 8'h00;
    hit = 1'b1;
    if (c inside {[8'h41:8'h5A]}) begin
      res = c - 8'h41;
    end else if (c inside {[8'h61:8'h7A]}) begin
      res = c - 8'h61 + 8'd26;
    end else if (c inside {[8'h30:8'h39]}) begin
      res = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      res = 8'd62;
    end else if (c == 8'h2F) begin
      res = 8'd63;
    end else begin
      hit = 1'b0;
    end
    return {hit, res[5:0]};
  endfunction

  // bytes of a group holding cnt data characters, oldest in the top bits
  function automatic rec_t group_bytes(logic [GroupW-1:0] v, logic [CntW-1:0] cnt);
    rec_t r;
    r = '0;
    case (cnt)
      3'd4: begin
        r.bytes[0] = v[23:16];
        r.bytes[1] = v[15:8];
        r.bytes[2] = v[7:0];
        r.num      = 2'd3;
      end
      3'd3: begin
        r.bytes[0] = v[17:10];
        r.bytes[1] = v[9:2];
        r.num      = 2'd2;
      end
      3'd2: begin
        r.bytes[0] = v[11:4];
        r.num      = 2'd1;
      end
      default: begin
        r.num = 2'd0;
      end
    endcase
    return r;
  endfunction

endpackage

### rtl/b64d_front.sv
// front end: accepts characters, groups them and builds decoded group records
`timescale 1ns / 1ps

module b64d_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [7:0]            char_code_i,
  input  logic                  stream_end_i,
  output logic                  in_stall_o,
  input  b64d_pkg::fifo_status_t fifo_status_i,
  output logic                  push_o,
  output b64d_pkg::rec_t        rec_o
);

  logic [b64d_pkg::AccW-1:0]   acc_q, acc_d;
  logic [1:0]                  slot_q, slot_d;
  logic [b64d_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [6:0]                  sx;
  logic                        is_data;
  logic                        take;
  logic                        accept;
  logic [b64d_pkg::GroupW-1:0] val;
  logic [b64d_pkg::CntW-1:0]   cnt_new;
  b64d_pkg::rec_t              rec;
  logic                        push;

  assign in_stall_o = fifo_status_i.full;
  assign accept     = in_valid_i && !fifo_status_i.full;
  assign sx         = b64d_pkg::sextet_of(char_code_i);
  assign is_data    = sx[6];
  assign take       = is_data || (char_code_i == b64d_pkg::PadChar);
  assign val        = is_data ? {acc_q, sx[5:0]} : {6'b0, acc_q};
  assign cnt_new    = cnt_q + {{(b64d_pkg::CntW-1){1'b0}}, is_data};

  always_comb begin
    acc_d  = acc_q;
    slot_d = slot_q;
    cnt_d  = cnt_q;
    rec    = '0;
    push   = 1'b0;
    if (accept) begin
      if (take) begin
        if (slot_q == 2'd3) begin
          rec    = b64d_pkg::group_bytes(val, cnt_new);
          acc_d  = '0;
          slot_d = 2'd0;
          cnt_d  = '0;
        end else begin
          acc_d  = val[b64d_pkg::AccW-1:0];
          cnt_d  = cnt_new;
          slot_d = slot_q + 2'd1;
        end
      end
      if (stream_end_i) begin
        // flush a partial group as if padded
        if (slot_d != 2'd0) begin
          rec = b64d_pkg::group_bytes({6'b0, acc_d}, cnt_d);
        end
        acc_d    = '0;
        slot_d   = 2'd0;
        cnt_d    = '0;
        rec.done = 1'b1;
      end
      push = rec.done || (rec.num != 2'd0);
    end
  end

  assign push_o = push;
  assign rec_o  = rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      slot_q <= 2'd0;
      cnt_q  <= '0;
    end else begin
      acc_q  <= acc_d;
      slot_q <= slot_d;
      cnt_q  <= cnt_d;
    end
  end

  a_cnt_le_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= {1'b0, slot_q})
    else $error("more data characters than filled slots");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && stream_end_i) |=> (slot_q == 2'd0 && cnt_q == '0 && acc_q == '0))
    else $error("group state not cleared after stream end");

  a_empty_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (acc_q == '0))
    else $error("accumulator holds bits with no data characters");

endmodule

### rtl/b64d_fifo.sv
// short register queue of group records between front and back
`timescale 1ns / 1ps

module b64d_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  b64d_pkg::rec_t         rec_i,
  input  logic                   pop_i,
  output b64d_pkg::rec_t         head_o,
  output b64d_pkg::fifo_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  b64d_pkg::rec_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  assign head_o         = mem_q[rd_q];
  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == Full);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("pop from empty queue");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full)
    else $error("queue count beyond depth");

endmodule

### rtl/b64d_back.sv
// back end: sends the bytes of each queued group one beat at a time
`timescale 1ns / 1ps

module b64d_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  b64d_pkg::rec_t         head_i,
  input  b64d_pkg::fifo_status_t fifo_status_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             data_byte_o,
  output logic                   byte_valid_o,
  output logic                   stream_done_o
);

  logic [1:0] idx_q, idx_d;
  logic [1:0] last_idx;
  logic       beat;
  logic       has_bytes;

  assign has_bytes   = (head_i.num != 2'd0);
  assign last_idx    = has_bytes ? head_i.num - 2'd1 : 2'd0;
  assign out_valid_o = !fifo_status_i.empty;
  assign beat        = out_valid_o && !out_stall_i;
  assign pop_o       = beat && (idx_q == last_idx);

  always_comb begin
    idx_d = idx_q;
    if (pop_o) begin
      idx_d = 2'd0;
    end else if (beat) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

  assign data_byte_o   = has_bytes ? head_i.bytes[idx_q] : 8'h00;
  assign byte_valid_o  = has_bytes;
  assign stream_done_o = head_i.done && (idx_q == last_idx);

  a_idx_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (idx_q <= last_idx))
    else $error("beat index beyond group size");

  a_empty_beat_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_valid_o) |-> stream_done_o)
    else $error("byteless beat without stream end");

  a_idle_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> (idx_q == 2'd0))
    else $error("beat index left over with empty queue");

endmodule

### rtl/base64_stream_decoder_top.sv
// top level of the base64 stream decoder
// usage:
//   input channel: one character per beat on char_code_i, stream_end_i marks
//   the last character; a beat moves when in_valid_i is high and in_stall_o
//   is low. characters outside the alphabet and the pad are dropped.
//   output channel: one decoded byte per beat on data_byte_o; a beat moves
//   when out_valid_o is high and out_stall_i is low. a stream end that yields
//   no byte gives one beat with byte_valid_o low; stream_done_o marks the
//   last beat of a stream.
//   throughput: one character per cycle on the input and one byte per cycle
//   on the output while out_stall_i is low; a full record queue alone holds
//   the input side. the record of a group is queued when the character that
//   completes it (or the stream end) is taken; its first byte is valid once
//   earlier records are sent. reset clears the group state and empties the
//   queue. while the receiver stalls, the front keeps taking characters until
//   FifoDepth group records are waiting, then raises in_stall_o.
`timescale 1ns / 1ps

module base64_stream_decoder_top #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       stream_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic       stream_done_o
);

  b64d_pkg::fifo_status_t fifo_status;
  b64d_pkg::rec_t         push_rec;
  b64d_pkg::rec_t         head_rec;
  logic                   push;
  logic                   pop;

  b64d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .char_code_i   (char_code_i),
    .stream_end_i  (stream_end_i),
    .in_stall_o    (in_stall_o),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .rec_o         (push_rec)
  );

  b64d_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .rec_i    (push_rec),
    .pop_i    (pop),
    .head_o   (head_rec),
    .status_o (fifo_status)
  );

  b64d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_rec),
    .fifo_status_i (fifo_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_byte_o   (data_byte_o),
    .byte_valid_o  (byte_valid_o),
    .stream_done_o (stream_done_o)
  );

endmodule

### tb/base64_stream_decoder_top_tb.sv
// testbench of the base64 stream decoder: directed and random character streams, checked per beat
`timescale 1ns / 1ps

module base64_stream_decoder_top_tb;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned DrainCycles   = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       done;
  } byte_beat_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] char_code_i;
  logic       stream_end_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] data_byte_o;
  logic       byte_valid_o;
  logic       stream_done_o;

  byte_beat_t  expected_bytes[$];
  logic [17:0] grp_bits;
  int unsigned grp_slots;
  int unsigned grp_chars;

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned n_sent;
  int unsigned n_err;
  int unsigned quiet_cycles;

  base64_stream_decoder_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_code_i  (char_code_i),
    .stream_end_i (stream_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_byte_o  (data_byte_o),
    .byte_valid_o (byte_valid_o),
    .stream_done_o(stream_done_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic int sextet_value(logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  function automatic logic [7:0] alphabet_char(int unsigned v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return 8'("+");
    return 8'("/");
  endfunction

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 72) return alphabet_char($urandom_range(63));
    if (r < 82) return b64d_pkg::PadChar;
    return 8'($urandom_range(255));
  endfunction

  // queues the bytes of a group; returns how many
  function automatic int unsigned push_group(logic [23:0] w, int unsigned nchr);
    logic [23:0] aligned;
    int unsigned nb;
    byte_beat_t  b;
    nb = (nchr >= 2) ? nchr - 1 : 0;
    aligned = w << (6 * (4 - nchr));
    for (int unsigned k = 0; k < nb; k++) begin
      b.data = aligned[23 - 8 * k -: 8];
      b.vld  = 1'b1;
      b.done = 1'b0;
      expected_bytes.push_back(b);
    end
    return nb;
  endfunction

  task automatic predict_char(logic [7:0] c, logic last);
    int          v;
    logic [23:0] w;
    int unsigned nchr;
    int unsigned n;
    byte_beat_t  b;
    v = sextet_value(c);
    w = {6'b0, grp_bits};
    nchr = grp_chars;
    n = 0;
    if (v >= 0 || c == b64d_pkg::PadChar) begin
      if (v >= 0) begin
        w = (w << 6) | 24'(v);
        nchr++;
      end
      if (grp_slots == 3) begin
        n = push_group(w, nchr);
        grp_bits = '0;
        grp_slots = 0;
        grp_chars = 0;
      end else begin
        grp_bits = w[17:0];
        grp_chars = nchr;
        grp_slots++;
      end
    end
    if (last) begin
      if (grp_slots != 0) begin
        n = push_group({6'b0, grp_bits}, grp_chars);
      end
      grp_bits = '0;
      grp_slots = 0;
      grp_chars = 0;
      if (n == 0) begin
        b = '0;
        expected_bytes.push_back(b);
      end
      expected_bytes[$].done = 1'b1;
    end
  endtask

  // entered and left at a falling edge
  task automatic send_char(logic [7:0] c, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    char_code_i  <= c;
    stream_end_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    predict_char(c, last);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(string s, logic end_on_last);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], end_on_last && (i == s.len() - 1));
    end
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < snk_stall_pct);
  end

  always @(posedge clk_i) begin
    byte_beat_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected beat data=%h vld=%b done=%b", $time,
                 data_byte_o, byte_valid_o, stream_done_o);
        n_err++;
      end else begin
        e = expected_bytes.pop_front();
        if (data_byte_o !== e.data) begin
          $display("%0t: data_byte expected %h actual %h", $time, e.data, data_byte_o);
          n_err++;
        end
        if (byte_valid_o !== e.vld) begin
          $display("%0t: byte_valid expected %b actual %b", $time, e.vld, byte_valid_o);
          n_err++;
        end
        if (stream_done_o !== e.done) begin
          $display("%0t: stream_done expected %b actual %b", $time, e.done, stream_done_o);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired, %0d beats outstanding", $time, expected_bytes.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_alphabet_ends();
    send_text("AZaz09+/", 1'b0);
  endtask

  task automatic test_pad_placement();
    send_text("=A==", 1'b0);
    send_text("Q=U=", 1'b0);
    send_text("====", 1'b0);
  endtask

  task automatic test_ignored_and_stream_end();
    send_char(8'h00, 1'b0);
    send_char("@", 1'b0);
    send_char(8'hFF, 1'b1);
    send_text("QU", 1'b1);
    send_text("TWFu", 1'b1);
  endtask

  task automatic test_random_streams(int unsigned n_items);
    int unsigned start;
    int unsigned len;
    start = n_sent;
    while (n_sent - start < n_items) begin
      len = $urandom_range(1, 14);
      for (int unsigned i = 0; i < len; i++) begin
        send_char(pick_char(), (i == len - 1) && ($urandom_range(9) != 0));
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    char_code_i   = 8'h00;
    stream_end_i  = 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    n_sent        = 0;
    grp_bits      = '0;
    grp_slots     = 0;
    grp_chars     = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_alphabet_ends();
    test_pad_placement();
    test_ignored_and_stream_end();

    src_idle_pct = 0;
    snk_stall_pct = 0;
    test_random_streams(52);
    src_idle_pct = 86;
    snk_stall_pct = 0;
    test_random_streams(52);
    src_idle_pct = 0;
    snk_stall_pct = 86;
    test_random_streams(52);
    src_idle_pct = 27;
    snk_stall_pct = 27;
    test_random_streams(52);

    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (n_err == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_fifo.sv
rtl/b64d_back.sv
rtl/base64_stream_decoder_top.sv
tb/base64_stream_decoder_top_tb.sv
